### rtl/llis_pkg.sv
// ----------------------------------------------------------------------------
// llis_pkg
// Shared constants and helpers for the 2D line intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package llis_pkg;

    // Parallel tolerance register, in denominator units
    localparam int TOL_WIDTH = 48;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 48'd1;

    typedef logic [TOL_WIDTH-1:0] tol_t;

    // Width of one queue entry between front and back for a coordinate width:
    // found + num + den + day + dax + y1 + x1
    function automatic int ent_width(input int cw);
        return 8 * cw + 9;
    endfunction

endpackage

`default_nettype wire

### rtl/llis_fifo.sv
// ----------------------------------------------------------------------------
// llis_fifo
// Small register queue that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module llis_fifo
    import llis_pkg::*;
#(
    parameter int WIDTH = 201,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill count; pointers wrap at the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

### rtl/llis_front.sv
// ----------------------------------------------------------------------------
// llis_front
// Front pipeline: edge deltas, cross products, denominator and numerator,
// and the parallel test against the tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

module llis_front
    import llis_pkg::*;
#(
    parameter int CW = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [8*CW-1:0]           in_data,
    input  tol_t                      tol,
    output logic                      ent_valid,
    input  logic                      ent_ready,
    output logic [ent_width(CW)-1:0]  ent_data
);

    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int MW   = PW;
    localparam int CMPW = (MW > TOL_WIDTH) ? MW : TOL_WIDTH;

    typedef struct packed {
        logic                 found;
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] den;
        logic signed [DW-1:0] day;
        logic signed [DW-1:0] dax;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x1;
    } ent_t;

    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic                 adv;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DW-1:0] dax1_reg, day1_reg, dbx1_reg, dby1_reg, ex1_reg, ey1_reg;
    logic signed [CW-1:0] x1_1_reg, y1_1_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    logic signed [CW-1:0] x1_2_reg, y1_2_reg;
    logic signed [NW-1:0] den3_reg, num3_reg;
    logic signed [DW-1:0] dax3_reg, day3_reg;
    logic signed [CW-1:0] x1_3_reg, y1_3_reg;
    ent_t                 ent_reg;
    logic [MW-1:0]        den_mag;

    // Unpack the input beat
    assign x1 = in_data[0*CW +: CW];
    assign y1 = in_data[1*CW +: CW];
    assign x2 = in_data[2*CW +: CW];
    assign y2 = in_data[3*CW +: CW];
    assign x3 = in_data[4*CW +: CW];
    assign y3 = in_data[5*CW +: CW];
    assign x4 = in_data[6*CW +: CW];
    assign y4 = in_data[7*CW +: CW];

    // Whole pipeline holds when the last stage cannot enter the queue
    assign adv       = !(v4_reg && !ent_ready);
    assign in_ready  = adv;
    assign ent_valid = v4_reg;
    assign ent_data  = ent_reg;

    assign den_mag = den3_reg[NW-1] ? MW'(-den3_reg) : MW'(den3_reg);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // deltas
            dax1_reg <= DW'(x2) - DW'(x1);
            day1_reg <= DW'(y2) - DW'(y1);
            dbx1_reg <= DW'(x4) - DW'(x3);
            dby1_reg <= DW'(y4) - DW'(y3);
            ex1_reg  <= DW'(x1) - DW'(x3);
            ey1_reg  <= DW'(y1) - DW'(y3);
            x1_1_reg <= x1;
            y1_1_reg <= y1;
            // cross products
            p1_reg   <= dby1_reg * dax1_reg;
            p2_reg   <= dbx1_reg * day1_reg;
            p3_reg   <= dbx1_reg * ey1_reg;
            p4_reg   <= dby1_reg * ex1_reg;
            dax2_reg <= dax1_reg;
            day2_reg <= day1_reg;
            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            // denominator and numerator
            den3_reg <= NW'(p1_reg) - NW'(p2_reg);
            num3_reg <= NW'(p3_reg) - NW'(p4_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;
            // parallel test
            ent_reg.found <= CMPW'(den_mag) > CMPW'(tol);
            ent_reg.num   <= num3_reg;
            ent_reg.den   <= den3_reg;
            ent_reg.day   <= day3_reg;
            ent_reg.dax   <= dax3_reg;
            ent_reg.y1    <= y1_3_reg;
            ent_reg.x1    <= x1_3_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/llis_back.sv
// ----------------------------------------------------------------------------
// llis_back
// Back pipeline: magnitudes, split wide products, a one-bit-per-stage
// restoring divider for each axis, then offset, saturation and output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module llis_back
    import llis_pkg::*;
#(
    parameter int CW = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ent_valid,
    output logic                      ent_ready,
    input  logic [ent_width(CW)-1:0]  ent_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic signed [CW-1:0]      cross_x,
    output logic signed [CW-1:0]      cross_y,
    output logic                      overflow
);

    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int MW  = PW;
    localparam int LO  = MW / 2;
    localparam int HI  = MW - LO;
    localparam int PPW = MW + DW;
    localparam int QB  = CW + 1;
    localparam int VW  = CW + 3;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                 found;
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] den;
        logic signed [DW-1:0] day;
        logic signed [DW-1:0] dax;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x1;
    } ent_t;

    typedef struct packed {
        logic                 found;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic                 negx;
        logic                 negy;
        logic [MW-1:0]        md;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  bigx;
        logic  bigy;
    } dside_t;

    ent_t   ent;
    logic   adv;

    // magnitude stage
    logic           va_reg;
    side_t          sa_reg;
    logic [MW-1:0]  mn_reg;
    logic [DW-1:0]  mdx_reg, mdy_reg;
    // partial product stage
    logic           vb_reg;
    side_t          sb_reg;
    logic [LO+DW-1:0] pxl_reg, pyl_reg;
    logic [HI+DW-1:0] pxh_reg, pyh_reg;
    // full product stage
    logic           vc_reg;
    side_t          sc_reg;
    logic [PPW-1:0] px_reg, py_reg;
    // divider stages
    logic           dv_valid_reg [0:QB];
    dside_t         ds_reg       [0:QB];
    logic [MW-1:0]  rx_reg       [0:QB];
    logic [MW-1:0]  ry_reg       [0:QB];
    logic [QB-1:0]  plx_reg      [0:QB];
    logic [QB-1:0]  ply_reg      [0:QB];
    logic [QB-1:0]  qx_reg       [0:QB];
    logic [QB-1:0]  qy_reg       [0:QB];
    // output beat
    logic                 out_valid_reg;
    logic                 found_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic                 ovf_reg;

    logic [MW-1:0]        rx0, ry0;
    logic signed [VW-1:0] vx, vy;
    logic                 xhi, xlo, yhi, ylo;
    logic signed [CW-1:0] x_fin, y_fin;
    logic                 satx, saty;

    assign ent       = ent_data;
    assign adv       = !out_valid_reg || out_ready;
    assign ent_ready = adv;

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;
    assign overflow  = ovf_reg;

    // Valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            va_reg          <= ent_valid;
            vb_reg          <= va_reg;
            vc_reg          <= vb_reg;
            dv_valid_reg[0] <= vc_reg;
            for (int k = 1; k <= QB; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            out_valid_reg   <= dv_valid_reg[QB];
        end
    end

    // Magnitudes, split products, full products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg.found <= ent.found;
            sa_reg.x1    <= ent.x1;
            sa_reg.y1    <= ent.y1;
            sa_reg.negx  <= ent.num[NW-1] ^ ent.dax[DW-1] ^ ent.den[NW-1];
            sa_reg.negy  <= ent.num[NW-1] ^ ent.day[DW-1] ^ ent.den[NW-1];
            sa_reg.md    <= ent.den[NW-1] ? MW'(-ent.den) : MW'(ent.den);
            mn_reg       <= ent.num[NW-1] ? MW'(-ent.num) : MW'(ent.num);
            mdx_reg      <= ent.dax[DW-1] ? DW'(-ent.dax) : DW'(ent.dax);
            mdy_reg      <= ent.day[DW-1] ? DW'(-ent.day) : DW'(ent.day);

            sb_reg  <= sa_reg;
            pxl_reg <= mn_reg[LO-1:0] * mdx_reg;
            pxh_reg <= mn_reg[MW-1:LO] * mdx_reg;
            pyl_reg <= mn_reg[LO-1:0] * mdy_reg;
            pyh_reg <= mn_reg[MW-1:LO] * mdy_reg;

            sc_reg <= sb_reg;
            px_reg <= (PPW'(pxh_reg) << LO) + PPW'(pxl_reg);
            py_reg <= (PPW'(pyh_reg) << LO) + PPW'(pyl_reg);
        end
    end

    // Divider entry: quotient too large for the coordinate range is flagged
    assign rx0 = MW'(px_reg >> QB);
    assign ry0 = MW'(py_reg >> QB);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0].side <= sc_reg;
            ds_reg[0].bigx <= rx0 >= sc_reg.md;
            ds_reg[0].bigy <= ry0 >= sc_reg.md;
            rx_reg[0]      <= (rx0 >= sc_reg.md) ? '0 : rx0;
            ry_reg[0]      <= (ry0 >= sc_reg.md) ? '0 : ry0;
            plx_reg[0]     <= px_reg[QB-1:0];
            ply_reg[0]     <= py_reg[QB-1:0];
            qx_reg[0]      <= '0;
            qy_reg[0]      <= '0;
        end
    end

    // One quotient bit per stage on each axis
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [MW:0] tx, ty;
        logic        gex, gey;

        always_comb
        begin
            tx  = {rx_reg[k-1], plx_reg[k-1][QB-k]};
            ty  = {ry_reg[k-1], ply_reg[k-1][QB-k]};
            gex = tx >= {1'b0, ds_reg[k-1].side.md};
            gey = ty >= {1'b0, ds_reg[k-1].side.md};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ds_reg[k]  <= ds_reg[k-1];
                rx_reg[k]  <= gex ? MW'(tx - {1'b0, ds_reg[k-1].side.md}) : tx[MW-1:0];
                ry_reg[k]  <= gey ? MW'(ty - {1'b0, ds_reg[k-1].side.md}) : ty[MW-1:0];
                plx_reg[k] <= plx_reg[k-1];
                ply_reg[k] <= ply_reg[k-1];
                qx_reg[k]  <= {qx_reg[k-1][QB-2:0], gex};
                qy_reg[k]  <= {qy_reg[k-1][QB-2:0], gey};
            end
        end
    end

    // Offset from the start point and saturate
    always_comb
    begin
        vx = ds_reg[QB].side.negx
            ? VW'(ds_reg[QB].side.x1) - $signed(VW'(qx_reg[QB]))
            : VW'(ds_reg[QB].side.x1) + $signed(VW'(qx_reg[QB]));
        vy = ds_reg[QB].side.negy
            ? VW'(ds_reg[QB].side.y1) - $signed(VW'(qy_reg[QB]))
            : VW'(ds_reg[QB].side.y1) + $signed(VW'(qy_reg[QB]));
        xhi = vx > VW'(CMAX);
        xlo = vx < VW'(CMIN);
        yhi = vy > VW'(CMAX);
        ylo = vy < VW'(CMIN);

        priority if (ds_reg[QB].bigx)
            x_fin = ds_reg[QB].side.negx ? CMIN : CMAX;
        else if (xhi)
            x_fin = CMAX;
        else if (xlo)
            x_fin = CMIN;
        else
            x_fin = vx[CW-1:0];

        priority if (ds_reg[QB].bigy)
            y_fin = ds_reg[QB].side.negy ? CMIN : CMAX;
        else if (yhi)
            y_fin = CMAX;
        else if (ylo)
            y_fin = CMIN;
        else
            y_fin = vy[CW-1:0];

        satx = ds_reg[QB].bigx || xhi || xlo;
        saty = ds_reg[QB].bigy || yhi || ylo;
    end

    // Output beat register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= ds_reg[QB].side.found;
            cx_reg    <= ds_reg[QB].side.found ? x_fin : '0;
            cy_reg    <= ds_reg[QB].side.found ? y_fin : '0;
            ovf_reg   <= ds_reg[QB].side.found && (satx || saty);
        end
    end

endmodule

`default_nettype wire

### rtl/line_line_intersection_2d_unit.sv
// ----------------------------------------------------------------------------
// line_line_intersection_2d_unit
// Intersection of two infinite 2D lines in signed fixed point, with a
// parallel tolerance, exact truncating division and saturation.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: a_start_x..b_end_y
//  m_*      out  m_tvalid/m_tready    m_tdata: cross_x, cross_y
//                                     m_tuser: found, overflow
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: parallel_tolerance
//
// One beat per cycle sustained in both directions while m_tready stays high.
// The path runs through 4 front stages, one queue slot, 4 back stages,
// COORD_WIDTH+1 divider stages (one quotient bit each) and the output register.
// Reset clears all valid bits and sets the tolerance to 1.
// Front and back stall on their own; the queue of QUEUE_DEPTH entries
// sits between them, and the output register holds a beat until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module line_line_intersection_2d_unit
    import llis_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
    // b_end_x, b_end_y
    input  logic [8*COORD_WIDTH-1:0]               s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // cross_x, cross_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // found, overflow
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  tol_t                                   cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int EW    = ent_width(CW);
    localparam int OUT_W = ((2*CW+7)/8)*8;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    tol_t                 tol_reg;
    logic                 f_valid, f_ready;
    logic [EW-1:0]        f_data;
    logic                 b_valid, b_ready;
    logic [EW-1:0]        b_data;
    logic                 found;
    logic signed [CW-1:0] cross_x, cross_y;
    logic                 overflow;

    // Tolerance register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    llis_front #(.CW(CW)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .tol       (tol_reg),
        .ent_valid (f_valid),
        .ent_ready (f_ready),
        .ent_data  (f_data)
    );

    llis_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    llis_back #(.CW(CW)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ent_valid (b_valid),
        .ent_ready (b_ready),
        .ent_data  (b_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .found     (found),
        .cross_x   (cross_x),
        .cross_y   (cross_y),
        .overflow  (overflow)
    );

    // Output beat packing
    assign m_tdata = OUT_W'({cross_y, cross_x});
    assign m_tuser = {overflow, found};

`ifndef SYNTH
    // Parallel result carries a zero point and no overflow
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !found) |-> (cross_x == '0 && cross_y == '0 && !overflow))
        else $error("parallel result not cleared");

    // Overflow only with a coordinate at a range limit
    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && overflow) |-> (cross_x == CMAX || cross_x == CMIN ||
                                    cross_y == CMAX || cross_y == CMIN))
        else $error("overflow without saturated coordinate");
`endif

endmodule

`default_nettype wire
